>>> design/dzb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dzb_pkg
// shared types, constants and saturation helpers for the d2q9 velocity
// boundary cell pipeline
// ----------------------------------------------------------------------------
package dzb_pkg;

  localparam int unsigned NumDist = 9;

  // distribution indexes
  localparam int unsigned DRest      = 0;
  localparam int unsigned DEast      = 1;
  localparam int unsigned DNorth     = 2;
  localparam int unsigned DWest      = 3;
  localparam int unsigned DSouth     = 4;
  localparam int unsigned DNorthEast = 5;
  localparam int unsigned DNorthWest = 6;
  localparam int unsigned DSouthWest = 7;
  localparam int unsigned DSouthEast = 8;

  // side flag bits
  localparam int unsigned BitTop   = 0;
  localparam int unsigned BitLeft  = 1;
  localparam int unsigned BitRight = 2;

  localparam logic [31:0] QMax   = 32'h7fff_ffff;
  localparam logic [31:0] QMin   = 32'h8000_0000;
  localparam logic [32:0] QOne   = 33'h0_4000_0000;
  // ceil(2^32 / 3), exact floor(a/3) for a below 2^31
  localparam logic [31:0] Recip3 = 32'h5555_5556;

  typedef logic [31:0] dist_t;

  typedef struct packed {
    dist_t [NumDist-1:0] f;
    logic [30:0]         u;
    logic [2:0]          flags;
    logic                sat;
  } cell_t;

  typedef struct packed {
    cell_t       item;
    logic [31:0] rho;
  } rho_t;

  typedef struct packed {
    cell_t       item;
    logic [31:0] t6;
    logic [31:0] t23;
  } term_t;

  typedef struct packed {
    cell_t       item;
    logic [34:0] mag;
    logic        neg;
    logic [31:0] den;
    logic        hit;
  } div_in_t;

  function automatic logic signed [35:0] sx36(input logic [31:0] x);
    return {{4{x[31]}}, x};
  endfunction

  function automatic logic sat_hit(input logic signed [35:0] v);
    return (v[35:31] != {5{v[31]}});
  endfunction

  function automatic logic [31:0] sat_val(input logic signed [35:0] v);
    logic [31:0] r;
    if (sat_hit(v)) begin
      r = v[35] ? QMin : QMax;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor(v / 3) for the small correction term
  function automatic logic [1:0] div3_small(input logic [3:0] v);
    logic [1:0] r;
    unique case (v)
      4'd0, 4'd1, 4'd2:   r = 2'd0;
      4'd3, 4'd4, 4'd5:   r = 2'd1;
      4'd6, 4'd7, 4'd8:   r = 2'd2;
      4'd9, 4'd10, 4'd11: r = 2'd3;
      default:            r = 2'd3;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/dzb_term.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dzb_term
// four stage unit for rho*uo/6 and 2*rho*uo/3, truncated toward zero
// ----------------------------------------------------------------------------
module dzb_term (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  dzb_pkg::rho_t  data_i,
  output logic           valid_o,
  output dzb_pkg::term_t data_o
);
  import dzb_pkg::*;

  logic [2:0] vld_q;
  logic       vout_q;

  cell_t              cell1_q, cell2_q, cell3_q;
  logic signed [62:0] prod_d, prod_q;
  logic [62:0]        pm;
  logic [30:0]        a2_q, a3_q;
  logic [1:0]         cb2_q, cb3_q;
  logic               neg2_q, neg3_q;
  logic [62:0]        m3;
  logic [29:0]        qa3_q;
  logic [30:0]        three;
  logic [30:0]        remv;
  logic [31:0]        t23m, t6m;
  term_t              out_d, out_q;

  assign prod_d = $signed(data_i.rho) * $signed(data_i.item.u);
  assign pm     = prod_q[62] ? 63'(-prod_q) : 63'(prod_q);
  assign m3     = {32'b0, a2_q} * {31'b0, Recip3};

  always_comb begin
    three       = {1'b0, qa3_q} + {qa3_q, 1'b0};
    remv        = a3_q - three;
    t23m        = {qa3_q, 2'b00} + {30'b0, div3_small({remv[1:0], cb3_q})};
    t6m         = {2'b00, qa3_q};
    out_d.item  = cell3_q;
    out_d.t6    = neg3_q ? -t6m : t6m;
    out_d.t23   = neg3_q ? -t23m : t23m;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      vld_q  <= {vld_q[1:0], valid_i};
      vout_q <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell1_q <= data_i.item;
      prod_q  <= prod_d;
      cell2_q <= cell1_q;
      a2_q    <= pm[61:31];
      cb2_q   <= pm[30:29];
      neg2_q  <= prod_q[62];
      cell3_q <= cell2_q;
      a3_q    <= a2_q;
      cb3_q   <= cb2_q;
      neg3_q  <= neg2_q;
      qa3_q   <= m3[61:32];
      out_q   <= out_d;
    end
  end

  assign valid_o = vout_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

>>> design/dzb_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dzb_div
// pipelined density divider: range check, 8 radix-2 stages of 4 bits,
// sign and saturation
// ----------------------------------------------------------------------------
module dzb_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  dzb_pkg::div_in_t data_i,
  output logic             valid_o,
  output dzb_pkg::rho_t    data_o
);
  import dzb_pkg::*;

  localparam int unsigned NumSteps = 8;
  localparam int unsigned BitsPerStep = 4;

  typedef struct packed {
    cell_t       item;
    logic [31:0] rem;
    logic [31:0] q;
    logic [31:0] den;
    logic [1:0]  lo;
    logic        neg;
    logic        ge;
    logic        gt;
    logic        hit;
  } div_st_t;

  function automatic div_st_t div_step(input div_st_t s);
    div_st_t     r;
    logic [32:0] r2;
    logic [32:0] diff;
    r = s;
    for (int i = 0; i < BitsPerStep; i++) begin
      r2   = {r.rem, r.lo[1]};
      diff = r2 - {1'b0, r.den};
      r.lo = {r.lo[0], 1'b0};
      if (r2 >= {1'b0, r.den}) begin
        r.rem = diff[31:0];
        r.q   = {r.q[30:0], 1'b1};
      end else begin
        r.rem = r2[31:0];
        r.q   = {r.q[30:0], 1'b0};
      end
    end
    return r;
  endfunction

  div_st_t            st_q [NumSteps+1];
  logic [NumSteps:0]  vld_q;
  div_st_t            st0_d;
  logic [32:0]        den2;
  rho_t               out_d, out_q;
  logic               vout_q;
  logic [31:0]        quo;
  logic               clamp;

  // range check and first partial remainder
  always_comb begin
    den2        = {data_i.den, 1'b0};
    st0_d.item  = data_i.item;
    st0_d.rem   = data_i.mag[33:2];
    st0_d.q     = '0;
    st0_d.den   = data_i.den;
    st0_d.lo    = data_i.mag[1:0];
    st0_d.neg   = data_i.neg;
    st0_d.ge    = data_i.mag >= {2'b00, den2};
    st0_d.gt    = data_i.mag > {2'b00, den2};
    st0_d.hit   = data_i.hit;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar k = 1; k <= NumSteps; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= div_step(st_q[k-1]);
      end
    end
  end

  // sign and clamp
  always_comb begin
    quo   = {1'b0, st_q[NumSteps].q[30:0]};
    clamp = st_q[NumSteps].ge && (!st_q[NumSteps].neg || st_q[NumSteps].gt);
    out_d.item = st_q[NumSteps].item;
    out_d.item.sat = st_q[NumSteps].item.sat | (st_q[NumSteps].hit & clamp);
    if (st_q[NumSteps].ge) begin
      out_d.rho = st_q[NumSteps].neg ? QMin : QMax;
    end else begin
      out_d.rho = st_q[NumSteps].neg ? -quo : quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      vld_q  <= {vld_q[NumSteps-1:0], valid_i};
      vout_q <= vld_q[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = vout_q;
  assign data_o  = out_q;

  // in range the quotient never reaches two
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumSteps] && !st_q[NumSteps].ge |-> !st_q[NumSteps].q[31])
    else $error("dzb_div: quotient out of range");

endmodule
`default_nettype wire

>>> design/d2q9_velocity_boundary_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2q9_velocity_boundary_cell
// zou-he style velocity boundary for one d2q9 cell: top inlet, left inlet,
// right outlet in that order, signed q2.30 with saturation
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | carries
//  --------+----------------------------------+-----------+------------------
//  in      | in_valid_i / in_ready_o          | into      | f_*, uo, flags
//  out     | out_valid_o / out_ready_i        | out of    | out_*, saturated
//
//  one request per cycle is accepted while the pipe advances; from accept to
//  result valid a request passes the top side (sum, 4 term stages, apply),
//  then left and right each (sum, 10 divider stages, 4 term stages, apply)
//  the whole pipe advances together whenever the output register is empty
//  or taken; a waiting result freezes every stage, nothing lost or doubled
//  reset clears only the valid bits, payload registers are left as is
// ----------------------------------------------------------------------------
module d2q9_velocity_boundary_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] f_rest_i,
  input  logic signed [31:0] f_east_i,
  input  logic signed [31:0] f_north_i,
  input  logic signed [31:0] f_west_i,
  input  logic signed [31:0] f_south_i,
  input  logic signed [31:0] f_northeast_i,
  input  logic signed [31:0] f_northwest_i,
  input  logic signed [31:0] f_southwest_i,
  input  logic signed [31:0] f_southeast_i,
  input  logic signed [30:0] uo_i,
  input  logic        [2:0]  side_flags_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_rest_o,
  output logic signed [31:0] out_east_o,
  output logic signed [31:0] out_north_o,
  output logic signed [31:0] out_west_o,
  output logic signed [31:0] out_south_o,
  output logic signed [31:0] out_northeast_o,
  output logic signed [31:0] out_northwest_o,
  output logic signed [31:0] out_southwest_o,
  output logic signed [31:0] out_southeast_o,
  output logic               saturated_o
);
  import dzb_pkg::*;

  // global advance: output register empty or being taken
  logic en;

  cell_t   in_cell;

  // top inlet side
  rho_t    ts_d, ts_q;
  logic    vts_q;
  term_t   tt;
  logic    vtt;
  cell_t   ta_d, ta_q;
  logic    vta_q;

  // left inlet side
  div_in_t ls_d, ls_q;
  logic    vls_q;
  rho_t    ld;
  logic    vld;
  term_t   lt;
  logic    vlt;
  cell_t   la_d, la_q;
  logic    vla_q;

  // right outlet side
  div_in_t rs_d, rs_q;
  logic    vrs_q;
  rho_t    rd;
  logic    vrd;
  term_t   rt;
  logic    vrt;
  cell_t   ra_d, ra_q;
  logic    vra_q;

  logic signed [35:0] top_sum;
  logic signed [35:0] left_sum;
  logic signed [35:0] right_sum;
  logic signed [35:0] left_abs;
  logic signed [35:0] right_abs;
  logic [32:0]        left_den;
  logic [32:0]        right_den;
  logic signed [35:0] ta_s8, ta_s7;
  logic signed [35:0] la_s1, la_s5, la_s8;
  logic signed [35:0] ra_s3, ra_s7, ra_s6;

  assign en         = !vra_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    in_cell.f[DRest]      = f_rest_i;
    in_cell.f[DEast]      = f_east_i;
    in_cell.f[DNorth]     = f_north_i;
    in_cell.f[DWest]      = f_west_i;
    in_cell.f[DSouth]     = f_south_i;
    in_cell.f[DNorthEast] = f_northeast_i;
    in_cell.f[DNorthWest] = f_northwest_i;
    in_cell.f[DSouthWest] = f_southwest_i;
    in_cell.f[DSouthEast] = f_southeast_i;
    in_cell.u             = uo_i;
    in_cell.flags         = side_flags_i;
    in_cell.sat           = 1'b0;
  end

  // ---------------------------------------------------------------- top inlet
  // density is a plain sum, clamped to q2.30
  always_comb begin
    top_sum = sx36(in_cell.f[DRest]) + sx36(in_cell.f[DEast]) + sx36(in_cell.f[DWest])
            + ((sx36(in_cell.f[DNorth]) + sx36(in_cell.f[DNorthWest])
              + sx36(in_cell.f[DNorthEast])) <<< 1);
    ts_d.item     = in_cell;
    ts_d.rho      = sat_val(top_sum);
    ts_d.item.sat = in_cell.flags[BitTop] & sat_hit(top_sum);
  end

  dzb_term u_term_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vts_q),
    .data_i  (ts_q),
    .valid_o (vtt),
    .data_o  (tt)
  );

  // with the top flag set, south copies north and diagonals get the shear term
  always_comb begin
    ta_d  = tt.item;
    ta_s8 = sx36(tt.item.f[DNorthWest]) + sx36(tt.t6);
    ta_s7 = sx36(tt.item.f[DNorthEast]) - sx36(tt.t6);
    if (tt.item.flags[BitTop]) begin
      ta_d.f[DSouth]     = tt.item.f[DNorth];
      ta_d.f[DSouthEast] = sat_val(ta_s8);
      ta_d.f[DSouthWest] = sat_val(ta_s7);
      ta_d.sat           = tt.item.sat | sat_hit(ta_s8) | sat_hit(ta_s7);
    end
  end

  // --------------------------------------------------------------- left inlet
  // numerator magnitude and sign, denominator 1 - uo
  always_comb begin
    left_sum = sx36(ta_q.f[DRest]) + sx36(ta_q.f[DNorth]) + sx36(ta_q.f[DSouth])
             + ((sx36(ta_q.f[DWest]) + sx36(ta_q.f[DNorthWest])
               + sx36(ta_q.f[DSouthWest])) <<< 1);
    left_abs = left_sum[35] ? -left_sum : left_sum;
    left_den = QOne - {{2{ta_q.u[30]}}, ta_q.u};
    ls_d.item = ta_q;
    ls_d.mag  = left_abs[34:0];
    ls_d.neg  = left_sum[35];
    ls_d.den  = left_den[31:0];
    ls_d.hit  = ta_q.flags[BitLeft];
  end

  dzb_div u_div_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vls_q),
    .data_i  (ls_q),
    .valid_o (vld),
    .data_o  (ld)
  );

  dzb_term u_term_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld),
    .data_i  (ld),
    .valid_o (vlt),
    .data_o  (lt)
  );

  always_comb begin
    la_d  = lt.item;
    la_s1 = sx36(lt.item.f[DWest]) + sx36(lt.t23);
    la_s5 = sx36(lt.item.f[DSouthWest]) + sx36(lt.t6);
    la_s8 = sx36(lt.item.f[DNorthWest]) + sx36(lt.t6);
    if (lt.item.flags[BitLeft]) begin
      la_d.f[DEast]      = sat_val(la_s1);
      la_d.f[DNorthEast] = sat_val(la_s5);
      la_d.f[DSouthEast] = sat_val(la_s8);
      la_d.sat = lt.item.sat | sat_hit(la_s1) | sat_hit(la_s5) | sat_hit(la_s8);
    end
  end

  // ------------------------------------------------------------- right outlet
  // denominator 1 + uo, a zero denominator becomes one lsb
  always_comb begin
    right_sum = sx36(la_q.f[DRest]) + sx36(la_q.f[DNorth]) + sx36(la_q.f[DSouth])
              + ((sx36(la_q.f[DEast]) + sx36(la_q.f[DNorthEast])
                + sx36(la_q.f[DSouthEast])) <<< 1);
    right_abs = right_sum[35] ? -right_sum : right_sum;
    right_den = QOne + {{2{la_q.u[30]}}, la_q.u};
    rs_d.item = la_q;
    rs_d.mag  = right_abs[34:0];
    rs_d.neg  = right_sum[35];
    rs_d.den  = (right_den[31:0] == '0) ? 32'd1 : right_den[31:0];
    rs_d.hit  = la_q.flags[BitRight];
  end

  dzb_div u_div_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vrs_q),
    .data_i  (rs_q),
    .valid_o (vrd),
    .data_o  (rd)
  );

  dzb_term u_term_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vrd),
    .data_i  (rd),
    .valid_o (vrt),
    .data_o  (rt)
  );

  always_comb begin
    ra_d  = rt.item;
    ra_s3 = sx36(rt.item.f[DEast]) - sx36(rt.t23);
    ra_s7 = sx36(rt.item.f[DNorthEast]) - sx36(rt.t6);
    ra_s6 = sx36(rt.item.f[DSouthEast]) - sx36(rt.t6);
    if (rt.item.flags[BitRight]) begin
      ra_d.f[DWest]      = sat_val(ra_s3);
      ra_d.f[DSouthWest] = sat_val(ra_s7);
      ra_d.f[DNorthWest] = sat_val(ra_s6);
      ra_d.sat = rt.item.sat | sat_hit(ra_s3) | sat_hit(ra_s7) | sat_hit(ra_s6);
    end
  end

  // ----------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vts_q <= 1'b0;
      vta_q <= 1'b0;
      vls_q <= 1'b0;
      vla_q <= 1'b0;
      vrs_q <= 1'b0;
      vra_q <= 1'b0;
    end else if (en) begin
      vts_q <= in_valid_i;
      vta_q <= vtt;
      vls_q <= vta_q;
      vla_q <= vlt;
      vrs_q <= vla_q;
      vra_q <= vrt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ts_q <= ts_d;
      ta_q <= ta_d;
      ls_q <= ls_d;
      la_q <= la_d;
      rs_q <= rs_d;
      ra_q <= ra_d;
    end
  end

  // ------------------------------------------------------------------ outputs
  assign out_valid_o     = vra_q;
  assign out_rest_o      = ra_q.f[DRest];
  assign out_east_o      = ra_q.f[DEast];
  assign out_north_o     = ra_q.f[DNorth];
  assign out_west_o      = ra_q.f[DWest];
  assign out_south_o     = ra_q.f[DSouth];
  assign out_northeast_o = ra_q.f[DNorthEast];
  assign out_northwest_o = ra_q.f[DNorthWest];
  assign out_southwest_o = ra_q.f[DSouthWest];
  assign out_southeast_o = ra_q.f[DSouthEast];
  assign saturated_o     = ra_q.sat;

  // --------------------------------------------------------------- assertions
  // no side active means nothing can clamp
  a_no_side_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ra_q.flags == '0) |-> !saturated_o)
    else $error("d2q9 boundary: saturation without active side");

  // top inlet alone leaves south equal to north
  a_top_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ra_q.flags[BitTop] && !ra_q.flags[BitLeft] && !ra_q.flags[BitRight]
    |-> out_south_o == out_north_o)
    else $error("d2q9 boundary: top inlet south mismatch");

  // input side only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("d2q9 boundary: stall without waiting result");

endmodule
`default_nettype wire
